// ===== design/assert_macros.svh =====
// Assertion macros shared by the parser modules.
// HRP_ASSERT checks a property at every rising clock edge outside reset.
// HRP_ASSERT_NEXT checks that a condition in one cycle implies a result in the next.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define HRP_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
`define HRP_ASSERT_NEXT(lbl, clk, rstn, cond, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (cond) |=> (prop)) else $error(msg);
`else
`define HRP_ASSERT(lbl, clk, rstn, prop, msg)
`define HRP_ASSERT_NEXT(lbl, clk, rstn, cond, prop, msg)
`endif
`endif

// ===== design/hrp_pkg.sv =====
`default_nettype none

package hrp_pkg;

    // Character codes that steer the parser.
    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_LF    = 8'd10;
    localparam logic [7:0] CH_SP    = 8'd32;
    localparam logic [7:0] CH_COLON = 8'd58;
    localparam logic [7:0] CH_ZERO  = 8'd48;
    localparam logic [7:0] CH_NINE  = 8'd57;

    // Line byte counter and version position widths.
    localparam int CNT_W  = 10;
    localparam int VPOS_W = 4;

    // Version check: "HTTP/1." then digits.
    localparam logic [VPOS_W-1:0] VPOS_PREFIX_LEN = 4'd7;
    localparam logic [VPOS_W-1:0] VPOS_DONE       = 4'd8;

    // Parts of a line.
    localparam logic [1:0] PART_FIRST  = 2'd0;
    localparam logic [1:0] PART_SECOND = 2'd1;
    localparam logic [1:0] PART_THIRD  = 2'd2;

    typedef enum logic [3:0] {
        PH_REQ_READ      = 4'd0,
        PH_REQ_TERM      = 4'd1,
        PH_HDR_READ      = 4'd2,
        PH_HDR_TERM      = 4'd3,
        PH_HDR_CONT      = 4'd4,
        PH_DONE          = 4'd5,
        PH_ERR_MALFORMED = 4'd6,
        PH_ERR_VERSION   = 4'd7,
        PH_ERR_LENGTH    = 4'd8
    } phase_t;

    typedef enum logic [2:0] {
        KIND_NONE      = 3'd0,
        KIND_METHOD    = 3'd1,
        KIND_URI       = 3'd2,
        KIND_VERSION   = 3'd3,
        KIND_HDR_NAME  = 3'd4,
        KIND_HDR_VALUE = 3'd5,
        KIND_BODY      = 3'd6
    } kind_t;

    typedef enum logic [2:0] {
        NOTE_NONE     = 3'd0,
        NOTE_REQ_LINE = 3'd1,
        NOTE_HDR_DONE = 3'd2,
        NOTE_HDRS_END = 3'd3,
        NOTE_ERROR    = 3'd4
    } notice_t;

    typedef enum logic [1:0] {
        ERR_NONE      = 2'd0,
        ERR_MALFORMED = 2'd1,
        ERR_VERSION   = 2'd2,
        ERR_LENGTH    = 2'd3
    } err_t;

    typedef struct packed {
        phase_t              phase;
        logic [1:0]          part;
        logic [CNT_W-1:0]    count;
        logic [VPOS_W-1:0]   vpos;
        logic                vgood;
        logic                skip;
    } line_state_t;

    typedef struct packed {
        logic [7:0] data;
        kind_t      kind;
        notice_t    notice;
        err_t       code;
    } result_t;

    // Outcome of one stored byte: new state and at most one result word.
    typedef struct packed {
        line_state_t st;
        logic        valid;
        result_t     res;
    } store_out_t;

    // Results of one input byte, handed to the result queue.
    typedef struct packed {
        logic [1:0] n;
        result_t    res0;
        result_t    res1;
    } push_t;

    function automatic result_t make_res(logic [7:0] data, kind_t kind, notice_t notice,
                                         err_t code);
        result_t r;
        r.data   = data;
        r.kind   = kind;
        r.notice = notice;
        r.code   = code;
        return r;
    endfunction

    // Append a result word after those already gathered for this byte.
    function automatic push_t append(push_t p, result_t r);
        push_t o;
        o = p;
        if (p.n == 2'd0) begin
            o.res0 = r;
            o.n    = 2'd1;
        end
        else begin
            o.res1 = r;
            o.n    = 2'd2;
        end
        return o;
    endfunction

    // Fresh line state in the given phase.
    function automatic line_state_t clear_line(phase_t ph);
        line_state_t s;
        s.phase = ph;
        s.part  = PART_FIRST;
        s.count = '0;
        s.vpos  = '0;
        s.vgood = 1'b1;
        s.skip  = 1'b0;
        return s;
    endfunction

    function automatic logic in_error(phase_t ph);
        return (ph == PH_ERR_MALFORMED) || (ph == PH_ERR_VERSION) || (ph == PH_ERR_LENGTH);
    endfunction

    // Expected bytes of the version prefix.
    function automatic logic [7:0] prefix_char(logic [2:0] idx);
        logic [7:0] ch;
        case (idx)
            3'd0:    ch = 8'h48;
            3'd1:    ch = 8'h54;
            3'd2:    ch = 8'h54;
            3'd3:    ch = 8'h50;
            3'd4:    ch = 8'h2F;
            3'd5:    ch = 8'h31;
            3'd6:    ch = 8'h2E;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    // Store one byte of the request line or of a header line.
    function automatic store_out_t store_byte(line_state_t st, logic [7:0] c, logic header,
                                              logic [CNT_W-1:0] max_line);
        store_out_t o;
        o.st    = st;
        o.valid = 1'b0;
        o.res   = make_res(8'd0, KIND_NONE, NOTE_NONE, ERR_NONE);
        if (st.count >= max_line) begin
            o.st.phase = PH_ERR_LENGTH;
            o.valid    = 1'b1;
            o.res      = make_res(8'd0, KIND_NONE, NOTE_ERROR, ERR_LENGTH);
        end
        else begin
            o.st.count = st.count + 1'b1;
            if (!header) begin
                if (st.part == PART_FIRST) begin
                    if (c == CH_SP) begin
                        o.st.part = PART_SECOND;
                    end
                    else begin
                        o.valid = 1'b1;
                        o.res   = make_res(c, KIND_METHOD, NOTE_NONE, ERR_NONE);
                    end
                end
                else if (st.part == PART_SECOND) begin
                    if (c == CH_SP) begin
                        o.st.part = PART_THIRD;
                    end
                    else begin
                        o.valid = 1'b1;
                        o.res   = make_res(c, KIND_URI, NOTE_NONE, ERR_NONE);
                    end
                end
                else begin
                    if (st.vpos < VPOS_PREFIX_LEN) begin
                        if (c != prefix_char(st.vpos[2:0])) begin
                            o.st.vgood = 1'b0;
                        end
                    end
                    else if ((c < CH_ZERO) || (c > CH_NINE)) begin
                        o.st.vgood = 1'b0;
                    end
                    if (st.vpos < VPOS_DONE) begin
                        o.st.vpos = st.vpos + 1'b1;
                    end
                    o.valid = 1'b1;
                    o.res   = make_res(c, KIND_VERSION, NOTE_NONE, ERR_NONE);
                end
            end
            else begin
                if (st.part == PART_FIRST) begin
                    if (c == CH_COLON) begin
                        o.st.part = PART_SECOND;
                        o.st.skip = 1'b1;
                    end
                    else begin
                        o.valid = 1'b1;
                        o.res   = make_res(c, KIND_HDR_NAME, NOTE_NONE, ERR_NONE);
                    end
                end
                else if (!(st.skip && (c == CH_SP))) begin
                    o.st.skip = 1'b0;
                    o.valid   = 1'b1;
                    o.res     = make_res(c, KIND_HDR_VALUE, NOTE_NONE, ERR_NONE);
                end
            end
        end
        return o;
    endfunction

    // A CR waits for its LF; any other byte is stored.
    function automatic store_out_t read_byte(line_state_t st, logic [7:0] c, logic header,
                                             logic [CNT_W-1:0] max_line);
        store_out_t o;
        if (c == CH_CR) begin
            o.st       = st;
            o.st.phase = header ? PH_HDR_TERM : PH_REQ_TERM;
            o.valid    = 1'b0;
            o.res      = make_res(8'd0, KIND_NONE, NOTE_NONE, ERR_NONE);
        end
        else begin
            o = store_byte(st, c, header, max_line);
        end
        return o;
    endfunction

endpackage

`default_nettype wire

// ===== design/http_request_header_parser.sv =====
`default_nettype none
// HTTP/1.x request header parser.
// Input channel: data_byte with data_valid/data_ready carries one request byte per word.
// Output channel: out_byte, kind, notice, error_code and last_of_run with
// result_valid/result_ready carry one result word per handshake. A byte gives zero,
// one or two result words; last_of_run marks the final word of each byte.
// A byte is held in the input register, then parsed and written to the result queue,
// from whose head its result words are offered.
// Bytes are taken at one byte per cycle while each yields at most one word and the
// receiver takes every word; a byte with two words holds the output port for both
// of its handshakes. The four-word result queue paces this; a held byte is parsed only
// while two words fit. Reset clears the parser to await a request line, empties the queue
// and drops the held byte. When the receiver stalls, the queue fills, the held byte waits
// and data_ready falls; errors are sticky until reset.
module http_request_header_parser #(
    parameter int MAX_LINE = 512
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       data_valid,
    output logic            data_ready,
    input  wire logic [7:0] data_byte,
    output logic            result_valid,
    input  wire logic       result_ready,
    output logic [7:0]      out_byte,
    output logic [2:0]      kind,
    output logic [2:0]      notice,
    output logic [1:0]      error_code,
    output logic            last_of_run
);
    import hrp_pkg::*;

    logic          hold_valid_reg;
    logic [7:0]    hold_byte_reg;
    logic          take;
    logic          room;
    push_t         push;
    result_t       head;

    // The held byte is parsed when the queue has room; a new word may enter then.
    assign take       = hold_valid_reg && room;
    assign data_ready = !hold_valid_reg || take;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            hold_valid_reg <= 1'b0;
        end
        else if (data_ready) begin
            hold_valid_reg <= data_valid;
        end
    end

    always_ff @(posedge clk) begin
        if (data_ready && data_valid) begin
            hold_byte_reg <= data_byte;
        end
    end

    hrp_step #(
        .MAX_LINE (MAX_LINE)
    ) u_step (
        .clk   (clk),
        .rst_n (rst_n),
        .take  (take),
        .data  (hold_byte_reg),
        .push  (push)
    );

    hrp_result_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .ready     (result_ready),
        .valid     (result_valid),
        .head      (head),
        .head_last (last_of_run),
        .room      (room)
    );

    // Result word fields.
    assign out_byte   = head.data;
    assign kind       = head.kind;
    assign notice     = head.notice;
    assign error_code = head.code;

endmodule

`default_nettype wire

// ===== design/hrp_step.sv =====
`default_nettype none
`include "assert_macros.svh"

module hrp_step #(
    parameter int MAX_LINE = 512
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          take,
    input  wire logic [7:0]    data,
    output hrp_pkg::push_t     push
);
    import hrp_pkg::*;

    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_LINE);

    line_state_t state_reg;
    line_state_t state_next;
    store_out_t  s0;
    store_out_t  s1;
    push_t       p;
    result_t     null_res;

    // One parsing step for the held byte.
    always_comb begin
        null_res   = make_res(8'd0, KIND_NONE, NOTE_NONE, ERR_NONE);
        state_next = state_reg;
        p.n        = 2'd0;
        p.res0     = null_res;
        p.res1     = null_res;
        s0         = '0;
        s1         = '0;
        case (state_reg.phase)
            PH_REQ_READ, PH_HDR_READ: begin
                s0         = read_byte(state_reg, data, state_reg.phase == PH_HDR_READ,
                                       MAX_CNT);
                state_next = s0.st;
                if (s0.valid) begin
                    p = append(p, s0.res);
                end
            end
            PH_REQ_TERM: begin
                if (data == CH_LF) begin
                    if (state_reg.count == '0) begin
                        state_next.phase = PH_REQ_READ;
                    end
                    else if (state_reg.part < PART_THIRD) begin
                        state_next.phase = PH_ERR_MALFORMED;
                        p = append(p, make_res(8'd0, KIND_NONE, NOTE_ERROR, ERR_MALFORMED));
                    end
                    else if (!(state_reg.vgood && (state_reg.vpos >= VPOS_DONE))) begin
                        state_next.phase = PH_ERR_VERSION;
                        p = append(p, make_res(8'd0, KIND_NONE, NOTE_ERROR, ERR_VERSION));
                    end
                    else begin
                        state_next = clear_line(PH_HDR_READ);
                        p = append(p, make_res(8'd0, KIND_NONE, NOTE_REQ_LINE, ERR_NONE));
                    end
                end
                else begin
                    // A lone CR counts as data, then the byte is read as usual.
                    s0         = store_byte(state_reg, CH_CR, 1'b0, MAX_CNT);
                    state_next = s0.st;
                    if (s0.valid) begin
                        p = append(p, s0.res);
                    end
                    if (!in_error(s0.st.phase)) begin
                        state_next.phase = PH_REQ_READ;
                        s1 = read_byte(state_next, data, 1'b0, MAX_CNT);
                        state_next = s1.st;
                        if (s1.valid) begin
                            p = append(p, s1.res);
                        end
                    end
                end
            end
            PH_HDR_TERM: begin
                if (data == CH_LF) begin
                    if (state_reg.count == '0) begin
                        state_next.phase = PH_DONE;
                        p = append(p, make_res(8'd0, KIND_NONE, NOTE_HDRS_END, ERR_NONE));
                    end
                    else begin
                        state_next.phase = PH_HDR_CONT;
                    end
                end
                else begin
                    s0         = store_byte(state_reg, CH_CR, 1'b1, MAX_CNT);
                    state_next = s0.st;
                    if (s0.valid) begin
                        p = append(p, s0.res);
                    end
                    if (!in_error(s0.st.phase)) begin
                        state_next.phase = PH_HDR_READ;
                        s1 = read_byte(state_next, data, 1'b1, MAX_CNT);
                        state_next = s1.st;
                        if (s1.valid) begin
                            p = append(p, s1.res);
                        end
                    end
                end
            end
            PH_HDR_CONT: begin
                if (data == CH_SP) begin
                    // Folded line: the header goes on.
                    state_next.phase = PH_HDR_READ;
                    s0 = store_byte(state_next, data, 1'b1, MAX_CNT);
                    state_next = s0.st;
                    if (s0.valid) begin
                        p = append(p, s0.res);
                    end
                end
                else if (state_reg.part == PART_FIRST) begin
                    state_next.phase = PH_ERR_MALFORMED;
                    p = append(p, make_res(8'd0, KIND_NONE, NOTE_ERROR, ERR_MALFORMED));
                end
                else if (state_reg.count >= MAX_CNT) begin
                    state_next.phase = PH_ERR_LENGTH;
                    p = append(p, make_res(8'd0, KIND_NONE, NOTE_ERROR, ERR_LENGTH));
                end
                else begin
                    p = append(p, make_res(8'd0, KIND_NONE, NOTE_HDR_DONE, ERR_NONE));
                    s0 = read_byte(clear_line(PH_HDR_READ), data, 1'b1, MAX_CNT);
                    state_next = s0.st;
                    if (s0.valid) begin
                        p = append(p, s0.res);
                    end
                end
            end
            PH_DONE: begin
                p = append(p, make_res(data, KIND_BODY, NOTE_NONE, ERR_NONE));
            end
            PH_ERR_MALFORMED: begin
                p = append(p, make_res(8'd0, KIND_NONE, NOTE_ERROR, ERR_MALFORMED));
            end
            PH_ERR_VERSION: begin
                p = append(p, make_res(8'd0, KIND_NONE, NOTE_ERROR, ERR_VERSION));
            end
            PH_ERR_LENGTH: begin
                p = append(p, make_res(8'd0, KIND_NONE, NOTE_ERROR, ERR_LENGTH));
            end
            default: begin
                state_next.phase = PH_ERR_MALFORMED;
                p = append(p, make_res(8'd0, KIND_NONE, NOTE_ERROR, ERR_MALFORMED));
            end
        endcase
    end

    // Results go to the queue only for a byte that is taken this cycle.
    always_comb begin
        push      = p;
        push.n    = take ? p.n : 2'd0;
    end

    // Parser state.
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg <= clear_line(PH_REQ_READ);
        end
        else if (take) begin
            state_reg <= state_next;
        end
    end

    `HRP_ASSERT_NEXT(a_error_sticky, clk, rst_n, in_error(state_reg.phase), $stable(state_reg.phase), "error phase left")
    `HRP_ASSERT(a_count_bound, clk, rst_n, state_reg.count <= MAX_CNT, "line count beyond limit")

endmodule

`default_nettype wire

// ===== design/hrp_result_fifo.sv =====
`default_nettype none
`include "assert_macros.svh"

module hrp_result_fifo (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire hrp_pkg::push_t   push,
    input  wire logic             ready,
    output logic                  valid,
    output hrp_pkg::result_t      head,
    output logic                  head_last,
    output logic                  room
);
    import hrp_pkg::*;

    localparam int DEPTH = 4;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_QW = $clog2(DEPTH + 1);

    typedef struct packed {
        result_t res;
        logic    last;
    } entry_t;

    entry_t              mem [DEPTH];
    logic [PTR_W-1:0]    wr_ptr_reg;
    logic [PTR_W-1:0]    rd_ptr_reg;
    logic [CNT_QW-1:0]   count_reg;
    logic [CNT_QW-1:0]   count_next;
    logic [CNT_QW-1:0]   count_after_pop;
    logic                pop;
    entry_t              entry0;
    entry_t              entry1;

    // Head of the queue drives the output word.
    assign valid     = (count_reg != '0);
    assign pop       = valid && ready;
    assign head      = mem[rd_ptr_reg].res;
    assign head_last = mem[rd_ptr_reg].last;

    // A new byte may enter when two result words fit after this cycle's pop.
    assign count_after_pop = count_reg - CNT_QW'(pop);
    assign room            = (count_after_pop <= CNT_QW'(DEPTH - 2));
    assign count_next      = count_after_pop + CNT_QW'(push.n);

    // The final word of a byte carries the last mark.
    assign entry0 = '{res: push.res0, last: (push.n == 2'd1)};
    assign entry1 = '{res: push.res1, last: 1'b1};

    always_ff @(posedge clk) begin
        if (push.n != 2'd0) begin
            mem[wr_ptr_reg] <= entry0;
        end
        if (push.n == 2'd2) begin
            mem[wr_ptr_reg + 1'b1] <= entry1;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else begin
            wr_ptr_reg <= wr_ptr_reg + PTR_W'(push.n);
            rd_ptr_reg <= rd_ptr_reg + PTR_W'(pop);
            count_reg  <= count_next;
        end
    end

    `HRP_ASSERT(a_push_fits, clk, rst_n, (push.n == 2'd0) || (count_next <= CNT_QW'(DEPTH)), "result queue overflow")
    `HRP_ASSERT(a_empty_ptrs, clk, rst_n, (count_reg != '0) || (wr_ptr_reg == rd_ptr_reg), "queue pointers disagree")

endmodule

`default_nettype wire
